>>> src/dia_pkg.sv
package dia_pkg;

   // operating modes, encoded as on the result word
   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_MONITOR = 2'd1,
      MODE_ALERT   = 2'd2,
      MODE_ALARM   = 2'd3
   } mode_type;

   // fixed hold times and the trigger count for the alarm
   localparam logic [15:0] IDLE_DEBOUNCE_MS    = 16'd500;
   localparam logic [15:0] MONITOR_DEBOUNCE_MS = 16'd1000;
   localparam logic [1:0]  MULTI_TRIG_CNT      = 2'd2;

   // register file
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_GAS_WARN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_HI   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_LO   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALERT_DB  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_DB  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_TO  = 3'd5;

   localparam logic [11:0]        GAS_WARN_RST = 12'd400;
   localparam logic signed [11:0] TEMP_HI_RST  = 12'sd350;
   localparam logic signed [11:0] TEMP_LO_RST  = 12'sd50;
   localparam logic [15:0]        ALERT_DB_RST = 16'd200;
   localparam logic [15:0]        ALARM_DB_RST = 16'd3000;
   localparam logic [31:0]        ALARM_TO_RST = 32'd30000;

   // queue between classifier and state machine
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = 1;
   localparam int unsigned QUEUE_CNT_W = 2;

   // classified sample
   typedef struct packed {
      logic        armed;
      logic        motion;
      logic        gas_ok;
      logic        gas_high;
      logic        temp_bad;
      logic [31:0] now_ms;
   } item_type;

   // timing registers used by the state machine
   typedef struct packed {
      logic [15:0] alert_db;
      logic [15:0] alarm_db;
      logic [31:0] alarm_to;
   } timing_type;

endpackage

>>> src/dia_if.sv
interface dia_req_if;
   logic               valid;
   logic               ready;
   logic               armed;
   logic               motion;
   logic [11:0]        gas_level;
   logic               gas_ok;
   logic signed [11:0] temp_tenths;
   logic [31:0]        now_ms;

   modport source (output valid, armed, motion, gas_level, gas_ok, temp_tenths, now_ms,
                   input ready);
   modport sink   (input valid, armed, motion, gas_level, gas_ok, temp_tenths, now_ms,
                   output ready);
endinterface

interface dia_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [1:0] prior_mode;
   logic       alarm_on;
   logic       led_on;
   logic       changed;

   modport source (output valid, mode, prior_mode, alarm_on, led_on, changed,
                   input ready);
   modport sink   (input valid, mode, prior_mode, alarm_on, led_on, changed,
                   output ready);
endinterface

interface dia_csr_if;
   logic                             valid;
   logic                             ready;
   logic [dia_pkg::CSR_IDX_W-1:0]    index;
   logic [dia_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> src/debounced_intrusion_alarm_fsm.sv
// An accepted word is written into the queue, is taken from it by the state
// machine and shows its result from the output register.
// Throughput: one word per cycle while results are taken; the state machine
// commits one word per cycle into the output register, which frees as soon as
// the result is taken. A two-word queue lets the input side keep taking words
// while a result waits. Reset (synchronous, active high): mode idle, timers and
// flags cleared, queue emptied, registers back to their default values.
module debounced_intrusion_alarm_fsm (
   input  logic       clock,
   input  logic       reset,
   dia_req_if.sink    req_chan,
   dia_rsp_if.source  rsp_chan,
   dia_csr_if.sink    csr_chan
);

   // timing registers, held in the front end, consumed by the state machine
   dia_pkg::timing_type timing;

   // front end to queue
   logic               push_valid;
   logic               push_ready;
   dia_pkg::item_type  push_item;

   // queue to state machine
   logic               pop_valid;
   logic               pop_ready;
   dia_pkg::item_type  pop_item;

   // Front end: register file and sensor classification (gas over warning,
   // temperature out of window). None of this depends on the current mode.
   dia_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .csr        (csr_chan),
      .timing     (timing),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // Decoupling queue; req ready drops only when it is full.
   dia_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // Back end: desired-mode logic, debounce against the pending mode, alarm
   // timeout and the output register. State advances only when a word leaves
   // the queue, so stalls on the result side freeze everything cleanly.
   dia_back u_back (
      .clock     (clock),
      .reset     (reset),
      .timing    (timing),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp       (rsp_chan)
   );

endmodule

>>> src/dia_front.sv
module dia_front (
   input  logic                 clock,
   input  logic                 reset,
   dia_req_if.sink              req,
   dia_csr_if.sink              csr,
   output dia_pkg::timing_type  timing,
   output logic                 push_valid,
   input  logic                 push_ready,
   output dia_pkg::item_type    push_item
);

   logic [11:0]        gas_warn_ff, gas_warn_in;
   logic signed [11:0] temp_hi_ff, temp_hi_in;
   logic signed [11:0] temp_lo_ff, temp_lo_in;
   logic [15:0]        alert_db_ff, alert_db_in;
   logic [15:0]        alarm_db_ff, alarm_db_in;
   logic [31:0]        alarm_to_ff, alarm_to_in;

   assign csr.ready = 1'b1;

   always_comb begin
      gas_warn_in = gas_warn_ff;
      temp_hi_in  = temp_hi_ff;
      temp_lo_in  = temp_lo_ff;
      alert_db_in = alert_db_ff;
      alarm_db_in = alarm_db_ff;
      alarm_to_in = alarm_to_ff;
      if (csr.valid) begin
         unique case (csr.index)
            dia_pkg::CSR_GAS_WARN: gas_warn_in = csr.data[11:0];
            dia_pkg::CSR_TEMP_HI:  temp_hi_in  = $signed(csr.data[11:0]);
            dia_pkg::CSR_TEMP_LO:  temp_lo_in  = $signed(csr.data[11:0]);
            dia_pkg::CSR_ALERT_DB: alert_db_in = csr.data[15:0];
            dia_pkg::CSR_ALARM_DB: alarm_db_in = csr.data[15:0];
            dia_pkg::CSR_ALARM_TO: alarm_to_in = csr.data[31:0];
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gas_warn_ff <= dia_pkg::GAS_WARN_RST;
         temp_hi_ff  <= dia_pkg::TEMP_HI_RST;
         temp_lo_ff  <= dia_pkg::TEMP_LO_RST;
         alert_db_ff <= dia_pkg::ALERT_DB_RST;
         alarm_db_ff <= dia_pkg::ALARM_DB_RST;
         alarm_to_ff <= dia_pkg::ALARM_TO_RST;
      end else begin
         gas_warn_ff <= gas_warn_in;
         temp_hi_ff  <= temp_hi_in;
         temp_lo_ff  <= temp_lo_in;
         alert_db_ff <= alert_db_in;
         alarm_db_ff <= alarm_db_in;
         alarm_to_ff <= alarm_to_in;
      end
   end

   assign timing.alert_db = alert_db_ff;
   assign timing.alarm_db = alarm_db_ff;
   assign timing.alarm_to = alarm_to_ff;

   // sensor classification; state independent
   assign push_valid         = req.valid;
   assign req.ready          = push_ready;
   assign push_item.armed    = req.armed;
   assign push_item.motion   = req.motion;
   assign push_item.gas_ok   = req.gas_ok;
   assign push_item.gas_high = req.gas_level > gas_warn_ff;
   assign push_item.temp_bad = (req.temp_tenths > temp_hi_ff) || (req.temp_tenths < temp_lo_ff);
   assign push_item.now_ms   = req.now_ms;

endmodule

>>> src/dia_queue.sv
module dia_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  dia_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output dia_pkg::item_type pop_item
);

   dia_pkg::item_type                 slot_ff [dia_pkg::QUEUE_DEPTH];
   logic [dia_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [dia_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [dia_pkg::QUEUE_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                              push, pop;

   localparam logic [dia_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      dia_pkg::QUEUE_PTR_W'(dia_pkg::QUEUE_DEPTH - 1);
   localparam logic [dia_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
      dia_pkg::QUEUE_CNT_W'(dia_pkg::QUEUE_DEPTH);

   assign push_ready = cnt_ff != FULL_CNT;
   assign pop_valid  = cnt_ff != '0;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> src/dia_back.sv
module dia_back (
   input  logic                clock,
   input  logic                reset,
   input  dia_pkg::timing_type timing,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  dia_pkg::item_type   pop_item,
   dia_rsp_if.source           rsp
);

   dia_pkg::mode_type mode_ff, mode_in;
   dia_pkg::mode_type prior_ff, prior_in;
   dia_pkg::mode_type pend_ff, pend_in;
   dia_pkg::mode_type desired;
   logic [31:0]       pend_since_ff, pend_since_in;
   logic [31:0]       start_ff, start_in;
   logic              alarm_ff, alarm_in;
   logic              led_ff, led_in;
   logic              alarm_clr;
   logic              changed;
   logic [1:0]        trig_cnt;
   logic [31:0]       hold;
   logic              take;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_mode_ff, rsp_prior_ff;
   logic              rsp_alarm_ff, rsp_led_ff, rsp_changed_ff;

   assign pop_ready = !rsp_valid_ff || rsp.ready;
   assign take      = pop_valid && pop_ready;

   assign trig_cnt = {1'b0, pop_item.motion} + {1'b0, pop_item.gas_high}
                   + {1'b0, pop_item.temp_bad};

   // desired mode
   always_comb begin
      desired   = mode_ff;
      alarm_clr = 1'b0;
      unique case (mode_ff)
         dia_pkg::MODE_IDLE: begin
            if (pop_item.armed) desired = dia_pkg::MODE_MONITOR;
         end
         dia_pkg::MODE_MONITOR: begin
            if (!pop_item.armed) begin
               desired = dia_pkg::MODE_IDLE;
            end else if (pop_item.motion || (pop_item.gas_high && pop_item.gas_ok)
                         || pop_item.temp_bad) begin
               desired = dia_pkg::MODE_ALERT;
            end
         end
         dia_pkg::MODE_ALERT: begin
            if (!pop_item.armed) begin
               desired = dia_pkg::MODE_IDLE;
            end else if (trig_cnt >= dia_pkg::MULTI_TRIG_CNT
                         || (pop_item.motion && !pop_item.gas_ok)) begin
               desired = dia_pkg::MODE_ALARM;
            end else if (!pop_item.motion && pop_item.gas_ok && !pop_item.gas_high
                         && !pop_item.temp_bad) begin
               desired = dia_pkg::MODE_MONITOR;
            end
         end
         dia_pkg::MODE_ALARM: begin
            if (!pop_item.armed) begin
               desired   = dia_pkg::MODE_IDLE;
               alarm_clr = 1'b1;
            end else if ((pop_item.now_ms - start_ff) > timing.alarm_to) begin
               desired   = dia_pkg::MODE_MONITOR;
               alarm_clr = 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      unique case (desired)
         dia_pkg::MODE_ALARM:   hold = {16'd0, timing.alarm_db};
         dia_pkg::MODE_IDLE:    hold = {16'd0, dia_pkg::IDLE_DEBOUNCE_MS};
         dia_pkg::MODE_MONITOR: hold = {16'd0, dia_pkg::MONITOR_DEBOUNCE_MS};
         dia_pkg::MODE_ALERT:   hold = {16'd0, timing.alert_db};
      endcase
   end

   // debounce, commit and entry actions
   always_comb begin
      mode_in       = mode_ff;
      prior_in      = prior_ff;
      pend_in       = pend_ff;
      pend_since_in = pend_since_ff;
      start_in      = start_ff;
      led_in        = led_ff;
      alarm_in      = alarm_clr ? 1'b0 : alarm_ff;
      changed       = 1'b0;
      if (desired != mode_ff) begin
         if (pend_ff != desired) begin
            pend_in       = desired;
            pend_since_in = pop_item.now_ms;
         end else if ((pop_item.now_ms - pend_since_ff) >= hold) begin
            prior_in = mode_ff;
            mode_in  = desired;
            pend_in  = desired;
            changed  = 1'b1;
            if (desired == dia_pkg::MODE_IDLE || desired == dia_pkg::MODE_MONITOR) begin
               led_in = 1'b0;
            end else if (desired == dia_pkg::MODE_ALARM) begin
               led_in   = 1'b1;
               alarm_in = 1'b1;
               start_in = pop_item.now_ms;
            end
         end
      end else begin
         pend_in = mode_ff;
      end
   end

   assign rsp_valid_in = take || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= dia_pkg::MODE_IDLE;
         prior_ff      <= dia_pkg::MODE_IDLE;
         pend_ff       <= dia_pkg::MODE_IDLE;
         pend_since_ff <= '0;
         start_ff      <= '0;
         alarm_ff      <= 1'b0;
         led_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            mode_ff       <= mode_in;
            prior_ff      <= prior_in;
            pend_ff       <= pend_in;
            pend_since_ff <= pend_since_in;
            start_ff      <= start_in;
            alarm_ff      <= alarm_in;
            led_ff        <= led_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_mode_ff    <= mode_in;
         rsp_prior_ff   <= prior_in;
         rsp_alarm_ff   <= alarm_in;
         rsp_led_ff     <= led_in;
         rsp_changed_ff <= changed;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.mode       = rsp_mode_ff;
   assign rsp.prior_mode = rsp_prior_ff;
   assign rsp.alarm_on   = rsp_alarm_ff;
   assign rsp.led_on     = rsp_led_ff;
   assign rsp.changed    = rsp_changed_ff;

endmodule

>>> sim/debounced_intrusion_alarm_fsm_test.sv
`timescale 1ns / 100ps

module debounced_intrusion_alarm_fsm_test;
   import dia_pkg::*;

   // one sensor sample as offered on the request channel
   typedef struct {
      logic               armed;
      logic               motion;
      logic [11:0]        gas;
      logic               gas_ok;
      logic signed [11:0] temp;
      logic [31:0]        now;
   } sample_type;

   // one status word as seen on the response channel
   typedef struct packed {
      mode_type mode;
      mode_type prior;
      logic     alarm_on;
      logic     led_on;
      logic     changed;
   } status_type;

   logic clock;
   logic reset;

   dia_req_if req_if ();
   dia_rsp_if rsp_if ();
   dia_csr_if csr_if ();

   debounced_intrusion_alarm_fsm dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // samples waiting for the driver, status words waiting for the monitor
   sample_type sample_queue[$];
   status_type status_queue[$];
   sample_type cur_sample;

   // predictor copy of the register file
   logic [11:0]        warn_lvl  = GAS_WARN_RST;
   logic signed [11:0] temp_hi   = TEMP_HI_RST;
   logic signed [11:0] temp_lo   = TEMP_LO_RST;
   logic [15:0]        alert_db  = ALERT_DB_RST;
   logic [15:0]        alarm_db  = ALARM_DB_RST;
   logic [31:0]        alarm_to  = ALARM_TO_RST;

   // predictor copy of the state machine
   mode_type    cur_mode   = MODE_IDLE;
   mode_type    last_mode  = MODE_IDLE;
   mode_type    want_mode  = MODE_IDLE;
   logic [31:0] want_since = '0;
   logic [31:0] alarm_t0   = '0;
   logic        alarm_flag = 1'b0;
   logic        led_lvl    = 1'b0;

   int   n_taken = 0;
   int   n_bad = 0;
   int   send_gap = 0;
   int   stall_left = 0;
   logic calm = 1'b0;       // no idling on either side once set
   logic hold_off = 1'b0;   // long receiver hold-off
   logic [31:0] tick = '0;  // running millisecond stamp for generated samples

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("FAIL debounced_intrusion_alarm_fsm");
      $finish;
   end

   // debounce time for a target mode
   function automatic logic [31:0] hold_for(mode_type target);
      case (target)
         MODE_ALARM:   return {16'd0, alarm_db};
         MODE_IDLE:    return {16'd0, IDLE_DEBOUNCE_MS};
         MODE_MONITOR: return {16'd0, MONITOR_DEBOUNCE_MS};
         default:      return {16'd0, alert_db};
      endcase
   endfunction

   // advance the predicted machine by one sample, return the status word it shows
   function automatic status_type step_alarm_fsm(sample_type s);
      status_type r;
      logic       gas_high;
      logic       temp_bad;
      logic [1:0] trips;
      mode_type   target;
      gas_high = s.gas > warn_lvl;
      temp_bad = (s.temp > temp_hi) || (s.temp < temp_lo);
      trips    = {1'b0, s.motion} + {1'b0, gas_high} + {1'b0, temp_bad};
      target   = cur_mode;
      r.changed = 1'b0;

      case (cur_mode)
         MODE_IDLE: begin
            if (s.armed) target = MODE_MONITOR;
         end
         MODE_MONITOR: begin
            if (!s.armed)
               target = MODE_IDLE;
            else if (s.motion || (gas_high && s.gas_ok) || temp_bad)
               target = MODE_ALERT;
         end
         MODE_ALERT: begin
            if (!s.armed)
               target = MODE_IDLE;
            else if (trips >= MULTI_TRIG_CNT || (s.motion && !s.gas_ok))
               target = MODE_ALARM;
            else if (!s.motion && s.gas_ok && !gas_high && !temp_bad)
               target = MODE_MONITOR;
         end
         default: begin
            // alarm flag drops at once on disarm or timeout, before debounce
            if (!s.armed) begin
               target = MODE_IDLE;
               alarm_flag = 1'b0;
            end else if (s.now - alarm_t0 > alarm_to) begin
               target = MODE_MONITOR;
               alarm_flag = 1'b0;
            end
         end
      endcase

      if (target != cur_mode) begin
         if (want_mode != target) begin
            want_mode  = target;
            want_since = s.now;
         end else if (s.now - want_since >= hold_for(target)) begin
            last_mode = cur_mode;
            cur_mode  = target;
            r.changed = 1'b1;
            if (target == MODE_IDLE || target == MODE_MONITOR) begin
               led_lvl = 1'b0;
            end else if (target == MODE_ALARM) begin
               led_lvl    = 1'b1;
               alarm_t0   = s.now;
               alarm_flag = 1'b1;
            end
            want_mode = cur_mode;
         end
      end else begin
         want_mode = cur_mode;
      end

      r.mode     = cur_mode;
      r.prior    = last_mode;
      r.alarm_on = alarm_flag;
      r.led_on   = led_lvl;
      return r;
   endfunction

   // driver: holds a word until taken, valid stays up across back-to-back words
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) begin
            status_queue.push_back(step_alarm_fsm(cur_sample));
            n_taken++;
         end
         if (send_gap != 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
         end else if (!calm && sample_queue.size() != 0 && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 19) - 1;
            req_if.valid <= 1'b0;
         end else if (sample_queue.size() != 0) begin
            cur_sample = sample_queue.pop_front();
            req_if.valid       <= 1'b1;
            req_if.armed       <= cur_sample.armed;
            req_if.motion      <= cur_sample.motion;
            req_if.gas_level   <= cur_sample.gas;
            req_if.gas_ok      <= cur_sample.gas_ok;
            req_if.temp_tenths <= cur_sample.temp;
            req_if.now_ms      <= cur_sample.now;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // monitor: check each taken word against the oldest prediction
   always @(posedge clock) begin
      status_type got;
      status_type exp_word;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.mode     = mode_type'(rsp_if.mode);
            got.prior    = mode_type'(rsp_if.prior_mode);
            got.alarm_on = rsp_if.alarm_on;
            got.led_on   = rsp_if.led_on;
            got.changed  = rsp_if.changed;
            if (status_queue.size() == 0) begin
               n_bad++;
               $display("%0t: unexpected word mode=%0d prior=%0d alarm=%b led=%b changed=%b",
                        $time, got.mode, got.prior, got.alarm_on, got.led_on, got.changed);
            end else begin
               exp_word = status_queue.pop_front();
               if (got !== exp_word) begin
                  n_bad++;
                  $display("%0t: mismatch expected mode=%0d prior=%0d alarm=%b led=%b chg=%b",
                           $time, exp_word.mode, exp_word.prior, exp_word.alarm_on,
                           exp_word.led_on, exp_word.changed);
                  $display("%0t:          actual   mode=%0d prior=%0d alarm=%b led=%b chg=%b",
                           $time, got.mode, got.prior, got.alarm_on, got.led_on,
                           got.changed);
               end
            end
         end
         if (hold_off) begin
            rsp_if.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // long receiver hold-off while the sender keeps offering: fills the queue
   initial begin
      wait (n_taken >= 150);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (60) @(posedge clock);
      hold_off <= 1'b0;
   end

   // wait until every queued word is sent and answered
   task automatic settle();
      do @(posedge clock);
      while (sample_queue.size() != 0 || req_if.valid || status_queue.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock);
      while (!csr_if.ready);
      case (idx)
         CSR_GAS_WARN: warn_lvl = val[11:0];
         CSR_TEMP_HI:  temp_hi  = val[11:0];
         CSR_TEMP_LO:  temp_lo  = val[11:0];
         CSR_ALERT_DB: alert_db = val[15:0];
         CSR_ALARM_DB: alarm_db = val[15:0];
         CSR_ALARM_TO: alarm_to = val;
         default: ;
      endcase
   endtask

   task automatic program_limits(int gas, int hi, int lo, int adb, int aldb,
                                 logic [31:0] tmo);
      write_reg(CSR_GAS_WARN, 32'(gas));
      write_reg(CSR_TEMP_HI, 32'(hi));
      write_reg(CSR_TEMP_LO, 32'(lo));
      write_reg(CSR_ALERT_DB, 32'(adb));
      write_reg(CSR_ALARM_DB, 32'(aldb));
      write_reg(CSR_ALARM_TO, tmo);
      csr_if.valid <= 1'b0;
   endtask

   task automatic queue_sample(logic a, logic m, logic [11:0] g, logic ok,
                               logic signed [11:0] t, logic [31:0] now);
      sample_type s;
      s.armed  = a;
      s.motion = m;
      s.gas    = g;
      s.gas_ok = ok;
      s.temp   = t;
      s.now    = now;
      sample_queue.push_back(s);
   endtask

   function automatic logic [11:0] gas_under();
      return 12'($urandom_range(0, warn_lvl));
   endfunction

   function automatic logic [11:0] gas_over();
      if (warn_lvl == 12'd4095) return 12'd4095;
      return 12'($urandom_range(warn_lvl + 1, 4095));
   endfunction

   function automatic logic signed [11:0] temp_random();
      return 12'(int'($urandom_range(0, 1650)) - 400);
   endfunction

   function automatic logic signed [11:0] temp_inside();
      int lo;
      int hi;
      lo = int'(temp_lo);
      hi = int'(temp_hi);
      if (lo > hi) return temp_random();   // crossed limits: nothing is inside
      return 12'(lo + int'($urandom_range(0, hi - lo)));
   endfunction

   function automatic logic signed [11:0] temp_outside();
      int lo;
      int hi;
      lo = int'(temp_lo);
      hi = int'(temp_hi);
      if (hi < 1250 && ($urandom_range(0, 1) == 1 || lo <= -400))
         return 12'(hi + 1 + int'($urandom_range(0, 1250 - hi - 1)));
      if (lo > -400)
         return 12'(lo - 1 - int'($urandom_range(0, lo - 1 + 400)));
      return 12'sd0;
   endfunction

   // mostly short steps, now and then long enough to cover slow debounce and timeouts
   function automatic logic [31:0] time_step();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 400);
      if (r < 90) return $urandom_range(400, 3000);
      if (r < 97) return $urandom_range(3000, 40000);
      return $urandom_range(40000, 100000);
   endfunction

   // runs of one sensor scenario held over several samples, mixed with noise
   task automatic random_phase(int n);
      int         k;
      int         run;
      int         kind;
      sample_type s;
      k = 0;
      while (k < n) begin
         kind = $urandom_range(0, 9);
         run  = (kind >= 8) ? 1 : $urandom_range(2, 10);
         for (int r = 0; r < run && k < n; r++) begin
            s.armed  = 1'b1;
            s.motion = 1'b0;
            s.gas_ok = 1'b1;
            s.gas    = gas_under();
            s.temp   = temp_inside();
            case (kind)
               0: begin
                  s.armed  = 1'b0;
                  s.motion = 1'($urandom_range(0, 1));
                  s.gas_ok = 1'($urandom_range(0, 1));
               end
               1: ;
               2: s.motion = 1'b1;
               3: s.gas = gas_over();
               4: s.temp = temp_outside();
               5: begin
                  s.motion = 1'b1;
                  if ($urandom_range(0, 1) == 1) s.gas = gas_over();
                  else s.temp = temp_outside();
               end
               6: begin
                  s.motion = 1'b1;
                  s.gas_ok = 1'b0;
               end
               7: begin
                  s.gas    = gas_over();
                  s.gas_ok = 1'b0;
               end
               default: begin
                  s.armed  = 1'($urandom_range(0, 1));
                  s.motion = 1'($urandom_range(0, 1));
                  s.gas_ok = 1'($urandom_range(0, 1));
                  s.gas    = 12'($urandom_range(0, 4095));
                  s.temp   = temp_random();
                  tick     = $urandom;
               end
            endcase
            if (kind < 8) tick = tick + time_step();
            s.now = tick;
            sample_queue.push_back(s);
            k++;
         end
      end
   endtask

   initial begin
      int lo;
      reset              = 1'b1;
      csr_if.valid       = 1'b0;
      csr_if.index       = '0;
      csr_if.data        = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed walk through every mode at reset limits
      queue_sample(0, 0, 12'd0,    1, 12'sd0,    32'd0);
      queue_sample(1, 0, 12'd100,  1, 12'sd200,  32'd10);       // pend monitor
      queue_sample(1, 0, 12'd100,  1, 12'sd200,  32'd1010);     // commit monitor
      queue_sample(1, 0, 12'd4095, 0, 12'sd200,  32'd1100);     // gas high but flagged unsafe
      queue_sample(1, 0, 12'd0,    1, -12'sd400, 32'd1200);     // cold: pend alert
      queue_sample(1, 0, 12'd0,    1, 12'sd1250, 32'd1400);     // hot: commit alert
      queue_sample(1, 1, 12'd0,    0, 12'sd200,  32'd1500);     // motion with gas danger
      queue_sample(1, 1, 12'd0,    0, 12'sd200,  32'd4500);     // commit alarm
      queue_sample(1, 0, 12'd0,    1, 12'sd200,  32'd20000);
      queue_sample(1, 0, 12'd0,    1, 12'sd200,  32'd34501);    // timeout, flag drops
      queue_sample(1, 0, 12'd0,    1, 12'sd200,  32'd35501);    // commit monitor
      queue_sample(1, 1, 12'd500,  1, 12'sd200,  32'd35600);
      queue_sample(1, 1, 12'd500,  1, 12'sd200,  32'd35800);    // alert
      queue_sample(1, 1, 12'd500,  1, 12'sd200,  32'd35900);    // two trips: pend alarm
      queue_sample(1, 0, 12'd0,    1, 12'sd200,  32'd36000);    // pending target switches
      queue_sample(0, 0, 12'd0,    1, 12'sd200,  32'd36100);
      queue_sample(0, 1, 12'd4095, 0, 12'sd1250, 32'd36600);    // commit idle
      queue_sample(1, 0, 12'd0,    1, 12'sd200,  32'hFFFF_FE00);
      queue_sample(1, 0, 12'd0,    1, 12'sd200,  32'h0000_0300); // commit across the wrap
      queue_sample(1, 1, 12'd4095, 0, -12'sd1,   32'h0000_0400);
      queue_sample(1, 1, 12'd4095, 0, -12'sd1,   32'h7FFF_FFFF);
      settle();

      // zero alert and alarm debounce and timeout, gas never trips, temperature never trips
      program_limits(4095, 1250, -400, 0, 0, 32'd0);
      random_phase(60);
      settle();

      // crossed temperature limits, longest debounce, alarm never times out
      program_limits(0, -400, 1250, 65535, 65535, 32'hFFFF_FFFF);
      random_phase(50);
      settle();

      for (int p = 0; p < 4; p++) begin
         lo = int'($urandom_range(0, 800)) - 400;
         if (p == 3) calm = 1'b1;
         program_limits($urandom_range(100, 3500), lo + int'($urandom_range(50, 800)), lo,
                        $urandom_range(0, 500), $urandom_range(0, 1500),
                        $urandom_range(0, 8000));
         random_phase(85);
         settle();
      end

      repeat (10) @(posedge clock);
      if (n_bad == 0 && status_queue.size() == 0) begin
         $display("PASS debounced_intrusion_alarm_fsm");
      end else begin
         $display("FAIL debounced_intrusion_alarm_fsm");
      end
      $finish;
   end

endmodule
